// ===== src/running_median_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// running_median_filter_core_macros.svh
// Assertion macros shared by the median filter modules.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_FILTER_CORE_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_CORE_MACROS_SVH

`ifndef SYNTH

// Property checked on every clock edge outside reset.
`define RMF_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Same-cycle implication checked outside reset.
`define RMF_ASSERT_IMP(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`else

`define RMF_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define RMF_ASSERT_IMP(lbl, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

// ===== src/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int DATA_BITS       = 16;  // sample and median field width
  localparam int CFG_BITS        = 5;   // window_len register width
  localparam int WIN_LEN_RESET   = 5;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // latch sample and working slot
    logic fill_wr;   // write one entry of the priming sweep
    logic rd_rank;   // read rank of working slot
    logic rd_prev;   // read value currently at that rank
    logic start;     // pick direction, read first neighbor
    logic swap;      // move neighbor across, read next neighbor
    logic finish;    // place the new sample, advance oldest slot
    logic rd_hi;     // read upper middle value
    logic rd_lo;     // keep upper, read lower middle value
    logic out_load;  // load output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic primed;
    logic fill_done;
    logic has_first;
    logic go_on;
    logic has_next;
    logic out_free;
  } sts_t;

endpackage

// ===== src/rmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmf_ctrl
// Sequencer for one sample: prime, locate, bubble, place, read median.
// ----------------------------------------------------------------------------
`include "running_median_filter_core_macros.svh"

module rmf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  rmf_pkg::sts_t sts,
  output rmf_pkg::cmd_t cmd
);
  import rmf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_FILL    = 10'b00_0000_0010,
    S_RANK    = 10'b00_0000_0100,
    S_PREV    = 10'b00_0000_1000,
    S_DIR     = 10'b00_0001_0000,
    S_BUBBLE  = 10'b00_0010_0000,
    S_FINAL   = 10'b00_0100_0000,
    S_MED_HI  = 10'b00_1000_0000,
    S_MED_LO  = 10'b01_0000_0000,
    S_MED_AVG = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.primed ? S_RANK : S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_done) begin
          state_next = S_RANK;
        end
      end
      S_RANK: begin
        cmd.rd_rank = 1'b1;
        state_next  = S_PREV;
      end
      S_PREV: begin
        cmd.rd_prev = 1'b1;
        state_next  = S_DIR;
      end
      S_DIR: begin
        cmd.start  = 1'b1;
        state_next = sts.has_first ? S_BUBBLE : S_FINAL;
      end
      S_BUBBLE: begin
        if (sts.go_on) begin
          cmd.swap   = 1'b1;
          state_next = sts.has_next ? S_BUBBLE : S_FINAL;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        state_next = S_MED_HI;
      end
      S_MED_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_MED_LO;
      end
      S_MED_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_MED_AVG;
      end
      S_MED_AVG: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `RMF_ASSERT_IMP(a_fill_only_unprimed, clk, rst, state == S_FILL, !sts.primed, "fill while primed")
  `RMF_ASSERT_IMP(a_load_needs_room, clk, rst, cmd.out_load, sts.out_free, "output overrun")
  `RMF_ASSERT(a_accept_leaves_idle, clk, rst, (s_valid && s_ready) |=> (state != S_IDLE), "accept stuck")

endmodule

// ===== src/rmf_datapath.sv =====
// ----------------------------------------------------------------------------
// rmf_datapath
// Sorted value store, rank tables, window state and output register.
// ----------------------------------------------------------------------------
`include "running_median_filter_core_macros.svh"

module rmf_datapath #(
  parameter int MAX_WINDOW  = rmf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rmf_pkg::CFG_BITS-1:0] cfg_wr_data,
  input  logic [rmf_pkg::DATA_BITS-1:0] sample,
  input  rmf_pkg::cmd_t                cmd,
  output rmf_pkg::sts_t                sts,
  output logic                         m_valid,
  input  logic                         m_ready,
  output logic [rmf_pkg::DATA_BITS-1:0] m_data
);
  import rmf_pkg::*;

  localparam int IW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW      = $clog2(MAX_WINDOW + 1);
  localparam int SB      = SAMPLE_BITS;
  localparam int FB      = (SB < DATA_BITS) ? SB : DATA_BITS;
  localparam int LEN_RST = (WIN_LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_LEN_RESET;

  // value at each rank, rank of each slot, slot of each rank
  logic [SB-1:0] sorted_mem    [MAX_WINDOW];
  logic [IW-1:0] slot_rank_mem [MAX_WINDOW];
  logic [IW-1:0] rank_slot_mem [MAX_WINDOW];

  logic [LW-1:0] win_len;
  logic          primed;
  logic [IW-1:0] oldest;
  logic          out_valid;

  logic [SB-1:0]        samp;
  logic [IW-1:0]        slot;
  logic [IW-1:0]        ir;
  logic [IW-1:0]        jr;
  logic                 up;
  logic [IW-1:0]        fill_idx;
  logic [SB-1:0]        hi;
  logic [IW-1:0]        rd_sr;
  logic [IW-1:0]        rd_rs;
  logic [SB-1:0]        rd_sv;
  logic [DATA_BITS-1:0] out_data;

  logic [LW-1:0]        len_clamped;
  logic [SB-1:0]        samp_in;
  logic                 up_now;
  logic [IW-1:0]        first_jr;
  logic [IW-1:0]        next_jr;
  logic [IW-1:0]        mid;
  logic                 odd;
  logic [IW-1:0]        slot_adv;
  logic [SB:0]          pair_sum;
  logic [SB-1:0]        med;
  logic [DATA_BITS-1:0] med_ext;
  logic                 sv_we;
  logic [IW-1:0]        sv_waddr;
  logic [SB-1:0]        sv_wdata;
  logic                 sv_re;
  logic [IW-1:0]        sv_raddr;
  logic                 rs_we;
  logic [IW-1:0]        rs_waddr;
  logic [IW-1:0]        rs_wdata;
  logic                 sr_we;
  logic [IW-1:0]        sr_waddr;
  logic [IW-1:0]        sr_wdata;

  // zero reads as one, oversize saturates
  always_comb begin
    if (cfg_wr_data == '0) begin
      len_clamped = LW'(1);
    end else if (int'(cfg_wr_data) > MAX_WINDOW) begin
      len_clamped = LW'(MAX_WINDOW);
    end else begin
      len_clamped = LW'(cfg_wr_data);
    end
  end

  assign samp_in  = SB'(sample[FB-1:0]);
  assign up_now   = samp > rd_sv;
  assign first_jr = up_now ? IW'(ir + IW'(1)) : IW'(ir - IW'(1));
  assign next_jr  = up ? IW'(jr + IW'(1)) : IW'(jr - IW'(1));
  assign mid      = IW'(win_len >> 1);
  assign odd      = win_len[0];
  assign slot_adv = ((LW'(slot) + LW'(1)) >= win_len) ? '0 : IW'(slot + IW'(1));

  assign sts.primed    = primed;
  assign sts.fill_done = (fill_idx == IW'(MAX_WINDOW - 1));
  assign sts.has_first = up_now ? ((LW'(ir) + LW'(1)) < win_len) : (ir != '0);
  assign sts.go_on     = up ? (samp > rd_sv) : (samp < rd_sv);
  assign sts.has_next  = up ? ((LW'(jr) + LW'(1)) < win_len) : (jr != '0);
  assign sts.out_free  = !out_valid || m_ready;

  // median: middle value, or floor mean of the middle pair
  assign pair_sum = {1'b0, hi} + {1'b0, rd_sv};
  assign med      = odd ? hi : pair_sum[SB:1];

  always_comb begin
    med_ext         = '0;
    med_ext[FB-1:0] = med[FB-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len   <= LW'(LEN_RST);
      primed    <= 1'b0;
      oldest    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_len <= len_clamped;
        primed  <= 1'b0;
        oldest  <= '0;
      end else begin
        if (cmd.fill_wr && sts.fill_done) begin
          primed <= 1'b1;
        end
        if (cmd.finish) begin
          oldest <= slot_adv;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp     <= samp_in;
      slot     <= (LW'(oldest) >= win_len) ? '0 : oldest;
      fill_idx <= '0;
    end
    if (cmd.fill_wr) begin
      fill_idx <= IW'(fill_idx + IW'(1));
    end
    if (cmd.rd_prev) begin
      ir <= rd_sr;
    end
    if (cmd.start) begin
      up <= up_now;
      jr <= first_jr;
    end
    if (cmd.swap) begin
      ir <= jr;
      jr <= next_jr;
    end
    if (cmd.rd_lo) begin
      hi <= rd_sv;
    end
    if (cmd.out_load) begin
      out_data <= med_ext;
    end
  end

  // store port selection; the moving sample's own entries are written at finish
  always_comb begin
    sv_we    = 1'b0;
    sv_waddr = ir;
    sv_wdata = samp;
    rs_we    = 1'b0;
    rs_waddr = ir;
    rs_wdata = slot;
    sr_we    = 1'b0;
    sr_waddr = slot;
    sr_wdata = ir;
    if (cmd.fill_wr) begin
      sv_we    = 1'b1;
      sv_waddr = fill_idx;
      rs_we    = 1'b1;
      rs_waddr = fill_idx;
      rs_wdata = fill_idx;
      sr_we    = 1'b1;
      sr_waddr = fill_idx;
      sr_wdata = fill_idx;
    end else if (cmd.swap) begin
      sv_we    = 1'b1;
      sv_wdata = rd_sv;
      rs_we    = 1'b1;
      rs_wdata = rd_rs;
      sr_we    = 1'b1;
      sr_waddr = rd_rs;
    end else if (cmd.finish) begin
      sv_we = 1'b1;
      rs_we = 1'b1;
      sr_we = 1'b1;
    end
  end

  always_comb begin
    sv_re    = 1'b1;
    sv_raddr = rd_sr;
    if (cmd.rd_prev) begin
      sv_raddr = rd_sr;
    end else if (cmd.start) begin
      sv_re    = sts.has_first;
      sv_raddr = first_jr;
    end else if (cmd.swap) begin
      sv_re    = sts.has_next;
      sv_raddr = next_jr;
    end else if (cmd.rd_hi) begin
      sv_raddr = mid;
    end else if (cmd.rd_lo) begin
      sv_raddr = odd ? mid : IW'(mid - IW'(1));
    end else begin
      sv_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_we) begin
      sorted_mem[sv_waddr] <= sv_wdata;
    end
    if (sv_re) begin
      rd_sv <= sorted_mem[sv_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rank_slot_mem[rs_waddr] <= rs_wdata;
    end
    if (sv_re && (cmd.start || cmd.swap)) begin
      rd_rs <= rank_slot_mem[sv_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sr_we) begin
      slot_rank_mem[sr_waddr] <= sr_wdata;
    end
    if (cmd.rd_rank) begin
      rd_sr <= slot_rank_mem[slot];
    end
  end

  assign m_valid = out_valid;
  assign m_data  = out_data;

  `RMF_ASSERT(a_len_range, clk, rst, (win_len != '0) && (win_len <= LW'(MAX_WINDOW)), "bad window length")
  `RMF_ASSERT(a_oldest_in_window, clk, rst, LW'(oldest) < win_len, "oldest slot outside window")
  `RMF_ASSERT_IMP(a_swap_distinct, clk, rst, cmd.swap, (jr != ir) && (LW'(jr) < win_len), "bad swap rank")

endmodule

// ===== src/running_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// running_median_filter_core
// Sliding-window median of unsigned samples, one median word per sample word.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata[15:0] = sample
//  m_axis    out  m_axis_tvalid/tready        tdata[15:0] = median
//  cfg       in   cfg_wr_en (no wait)         cfg_wr_data[4:0] = window_len
//
//  A primed word runs rank lookup, direction pick, bubble pass, placement
//  and median read from accept to the next accept; the bubble pass moves
//  the new sample one rank per cycle through the one-read, one-write rank
//  and value stores. The first word after reset or after a window_len write
//  first runs a priming sweep that fills every slot.
//  Reset is synchronous, active high; it clears the sequencer, the output
//  valid flag and the window state (window_len back to 5).
//  A stalled m_axis holds the finished median in the output register; the
//  next sample word is still accepted and processed behind it.
//
// ----------------------------------------------------------------------------
module running_median_filter_core #(
  parameter int MAX_WINDOW  = rmf_pkg::MAX_WINDOW_DEF,   // deepest window
  parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF   // stored sample width
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rmf_pkg::DATA_BITS-1:0] s_axis_tdata,   // [15:0] sample
  // median words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rmf_pkg::DATA_BITS-1:0] m_axis_tdata,   // [15:0] median
  // window length register
  input  logic                          cfg_wr_en,
  input  logic [rmf_pkg::CFG_BITS-1:0]  cfg_wr_data     // [4:0] window_len
);
  import rmf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one sample word in flight at a time
  rmf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // stores, rank bookkeeping, median arithmetic and output register
  rmf_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (s_axis_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_data      (m_axis_tdata)
  );

endmodule
